// ----- rtl/core/okse_pkg.sv -----
package okse_pkg;

  localparam int KEY_W = 32;
  localparam int OP_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_MEMBER = 3'd2,
    OP_NEXT   = 3'd3,
    OP_PREV   = 3'd4
  } okse_op_t;

  // Control broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic cmp_en;
    logic shift_ins;
    logic shift_del;
  } okse_ctl_t;

endpackage

// ----- rtl/core/okse_cell.sv -----
module okse_cell import okse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  okse_ctl_t               ctl,
  input  logic signed [KEY_W-1:0] cmp_key,
  input  logic signed [KEY_W-1:0] ins_key,
  input  logic                    occ,
  input  logic signed [KEY_W-1:0] left_key,
  input  logic signed [KEY_W-1:0] right_key,
  input  logic                    left_lt,
  input  logic                    left_eq,
  input  logic                    right_lt,
  output logic signed [KEY_W-1:0] key_q,
  output logic                    lt_q,
  output logic                    eq_q,
  output logic                    sel_next,
  output logic                    sel_prev
);

  logic signed [KEY_W-1:0] key_r;
  logic                    lt_r;
  logic                    eq_r;
  logic                    occ_r;

  // Cells at or above the insert/delete point move one place; the rest hold
  always_ff @(posedge clk) begin
    if (ctl.shift_ins && !lt_r) begin
      key_r <= left_lt ? ins_key : left_key;
    end else if (ctl.shift_del && !lt_r) begin
      key_r <= right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r  <= 1'b0;
      eq_r  <= 1'b0;
      occ_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      lt_r  <= occ && (key_r < cmp_key);
      eq_r  <= occ && (key_r == cmp_key);
      occ_r <= occ;
    end
  end

  assign key_q    = key_r;
  assign lt_q     = lt_r;
  assign eq_q     = eq_r;
  // First occupied key above the probe, and last key below it
  assign sel_next = occ_r && !lt_r && !eq_r && (left_lt || left_eq);
  assign sel_prev = lt_r && !right_lt;

endmodule

// ----- rtl/core/ordered_key_set_engine_unit.sv -----
// Ordered key set: a sorted chain of CAPACITY key cells.
// Result: the cells register their compare flags when an item is accepted in ST_IDLE,
// then the result is registered when ST_CMP fires (shift and select); no new item is taken until then.
// A stalled result holds the shift until it can be taken.
// Reset (rst_n, synchronous, active low) empties the set and clears the handshake;
// the cell keys themselves are not cleared.
module ordered_key_set_engine_unit import okse_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_found,
  output logic signed [KEY_W-1:0] out_answer_key,
  output logic                    out_overflow
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CMP  = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [KEY_W-1:0] key_hold_r;
  okse_op_t                op_hold_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    found_r, found_nxt;
  logic signed [KEY_W-1:0] answer_r, answer_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    accept;
  logic                    fire;
  logic                    present;
  logic                    found_next;
  logic                    found_prev;
  logic signed [KEY_W-1:0] next_key;
  logic signed [KEY_W-1:0] prev_key;
  logic                    full;
  okse_ctl_t               ctl;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     cell_lt;
  logic [CAPACITY-1:0]     cell_eq;
  logic [CAPACITY-1:0]     cell_next;
  logic [CAPACITY-1:0]     cell_prev;

  assign in_stall = !(state_r == ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state_r == ST_CMP) && (!out_valid_r || !out_stall);
  assign full     = (count_r == CW'(CAPACITY));
  assign present  = |cell_eq;

  assign ctl.cmp_en    = accept;
  assign ctl.shift_ins = fire && (op_hold_r == OP_INSERT) && !present && !full;
  assign ctl.shift_del = fire && (op_hold_r == OP_DELETE) && present;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_W-1:0] lkey, rkey;
    logic                    llt, leq, rlt;

    if (i == 0) begin : g_first
      assign lkey = cell_key[i];
      assign llt  = 1'b1;
      assign leq  = 1'b0;
    end else begin : g_mid_l
      assign lkey = cell_key[i-1];
      assign llt  = cell_lt[i-1];
      assign leq  = cell_eq[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rkey = cell_key[i];
      assign rlt  = 1'b0;
    end else begin : g_mid_r
      assign rkey = cell_key[i+1];
      assign rlt  = cell_lt[i+1];
    end

    okse_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cmp_key  (in_key),
      .ins_key  (key_hold_r),
      .occ      (CW'(i) < count_r),
      .left_key (lkey),
      .right_key(rkey),
      .left_lt  (llt),
      .left_eq  (leq),
      .right_lt (rlt),
      .key_q    (cell_key[i]),
      .lt_q     (cell_lt[i]),
      .eq_q     (cell_eq[i]),
      .sel_next (cell_next[i]),
      .sel_prev (cell_prev[i])
    );
  end

  // Select flags are one-hot or all zero, so an AND-OR picks the neighbor key
  always_comb begin
    next_key = '0;
    prev_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      next_key = next_key | ({KEY_W{cell_next[i]}} & cell_key[i]);
      prev_key = prev_key | ({KEY_W{cell_prev[i]}} & cell_key[i]);
    end
  end

  assign found_next = |cell_next;
  assign found_prev = |cell_prev;

  always_comb begin
    found_nxt  = 1'b0;
    answer_nxt = '0;
    ovf_nxt    = 1'b0;
    count_nxt  = count_r;
    case (op_hold_r)
      OP_INSERT: begin
        found_nxt = present;
        ovf_nxt   = !present && full;
        if (!present && !full) begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        found_nxt = present;
        if (present) begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_MEMBER: found_nxt = present;
      OP_NEXT: begin
        found_nxt  = found_next;
        answer_nxt = next_key;
      end
      OP_PREV: begin
        found_nxt  = found_prev;
        answer_nxt = prev_key;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CMP;
      ST_CMP: begin
        if (fire) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_hold_r <= in_key;
      op_hold_r  <= okse_op_t'(in_operation);
    end
    if (fire) begin
      found_r  <= found_nxt;
      answer_r <= answer_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_answer_key = answer_r;
  assign out_overflow   = ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("key count above capacity");

  a_new_result_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == ST_CMP))
    else $error("result produced without a compare pass");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($onehot0(cell_next) && $onehot0(cell_prev)))
    else $error("neighbor select not one-hot");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_overflow && out_found))
    else $error("overflow flagged on a present key");

endmodule
